// ----- rtl/cgtr_pkg.sv -----
// Shared types and constants for the channel-group tensor reorder block.
`timescale 1ns / 1ps
`default_nettype none
package cgtr_pkg;

  localparam int CAPACITY = 16384;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  localparam int W_W     = 8;
  localparam int H_W     = 8;
  localparam int C_W     = 11;
  localparam int L_W     = 7;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 2;

  localparam int W_MAX = 128;
  localparam int H_MAX = 128;
  localparam int C_MAX = 1024;
  localparam int L_MAX = 64;

  localparam int LANE_W = 6;
  localparam int COL_W  = 7;
  localparam int GRP_W  = 10;
  localparam int ROW_W  = 7;

  localparam int WH_W    = 15;
  localparam int TOTAL_W = 25;

  localparam int DIV_STEPS  = C_W;
  localparam int CALC_CNT_W = $clog2(DIV_STEPS + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LANES    = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_PENDING = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;
  localparam logic [1:0] STAT_SIZE    = 2'd3;

  typedef enum logic [1:0] {
    ST_CALC,
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic div_init;
    logic div_step;
    logic load;
    logic rd_issue;
    logic rd_err;
    logic rd_resp;
  } ctl_cmd_t;

  typedef struct packed {
    logic too_big;
    logic empty;
    logic not_loaded;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/cgtr_ctrl.sv -----
// Controller state machine for the channel-group tensor reorder block.
`timescale 1ns / 1ps
`default_nettype none
module cgtr_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire                 mode,
  input  wire                 cfg_we,
  input  cgtr_pkg::dp_status_t st,
  output cgtr_pkg::ctl_cmd_t  cmd,
  output logic                busy
);
  import cgtr_pkg::*;

  state_t                 state, state_next;
  logic [CALC_CNT_W-1:0]  calc_cnt, calc_cnt_next;
  logic                   read_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CALC;
      calc_cnt <= '0;
    end else begin
      state    <= state_next;
      calc_cnt <= calc_cnt_next;
    end
  end

  assign read_ok = !st.too_big && !st.empty && !st.not_loaded;

  always_comb begin
    state_next    = state;
    calc_cnt_next = calc_cnt;
    cmd           = '0;
    busy          = 1'b1;
    case (state)
      ST_CALC: begin
        // init divider, then one quotient bit per cycle
        if (calc_cnt == '0) begin
          cmd.div_init = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
        end
        if (calc_cnt == CALC_CNT_W'(DIV_STEPS)) begin
          state_next    = ST_IDLE;
          calc_cnt_next = '0;
        end else begin
          calc_cnt_next = calc_cnt + CALC_CNT_W'(1);
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (!mode) begin
            cmd.load = 1'b1;
          end else if (read_ok) begin
            cmd.rd_issue = 1'b1;
            state_next   = ST_READ;
          end else begin
            cmd.rd_err = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.rd_resp = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // a register write restarts the derived-size computation
    if (cfg_we) begin
      state_next    = ST_CALC;
      calc_cnt_next = '0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cgtr_datapath.sv -----
// Datapath: config registers, size math, element store and address walker.
`timescale 1ns / 1ps
`default_nettype none
module cgtr_datapath (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire  [cgtr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [cgtr_pkg::CFG_W-1:0]           cfg_data,
  input  cgtr_pkg::ctl_cmd_t                   cmd,
  input  wire  signed [cgtr_pkg::DATA_W-1:0]   element_value,
  output cgtr_pkg::dp_status_t                 st,
  output logic                                 done,
  output logic signed [cgtr_pkg::DATA_W-1:0]   out_value,
  output logic [1:0]                           status,
  output logic                                 last_flag
);
  import cgtr_pkg::*;

  logic [W_W-1:0] reg_w;
  logic [H_W-1:0] reg_h;
  logic [C_W-1:0] reg_c;
  logic [L_W-1:0] reg_l;

  logic [W_W-1:0] w_eff;
  logic [H_W-1:0] h_eff;
  logic [C_W-1:0] c_eff;
  logic [L_W-1:0] l_eff;

  logic [WH_W-1:0]    wh;
  logic [TOTAL_W-1:0] total;
  logic [ADDR_W-1:0]  stride;

  logic [L_W-1:0] rem;
  logic [C_W-1:0] quo;
  logic [L_W:0]   div_r;
  logic           div_ge;

  logic [CNT_W-1:0]  loaded;
  logic [LANE_W-1:0] lane_pos;
  logic [COL_W-1:0]  col_pos;
  logic [GRP_W-1:0]  group_pos;
  logic [ROW_W-1:0]  row_pos;
  logic [ADDR_W-1:0] row_base, gstart, cbase, addr;
  logic [ADDR_W-1:0] gstart_nx, row_base_nx;

  logic lane_last, col_last, grp_last, row_last, last_now;
  logic load_ok, pend_last;
  logic [1:0] code;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata;

  assign w_eff = (reg_w > W_W'(W_MAX)) ? W_W'(W_MAX) : reg_w;
  assign h_eff = (reg_h > H_W'(H_MAX)) ? H_W'(H_MAX) : reg_h;
  assign c_eff = (reg_c > C_W'(C_MAX)) ? C_W'(C_MAX) : reg_c;
  assign l_eff = (reg_l > L_W'(L_MAX)) ? L_W'(L_MAX) : reg_l;

  // size products, registered: wh first, then total and stride from wh; settle during the calc window
  always_ff @(posedge clk) begin
    wh     <= WH_W'(w_eff * h_eff);
    total  <= TOTAL_W'(wh * c_eff);
    stride <= ADDR_W'(wh * l_eff);
  end

  // restoring divider: groups = channels / lanes
  assign div_r  = {rem, quo[C_W-1]};
  assign div_ge = div_r >= {1'b0, l_eff};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= '0;
      quo <= c_eff;
    end else if (cmd.div_step) begin
      rem <= div_ge ? L_W'(div_r - {1'b0, l_eff}) : L_W'(div_r);
      quo <= {quo[C_W-2:0], div_ge};
    end
  end

  assign st.too_big    = total > TOTAL_W'(CAPACITY);
  assign st.empty      = (w_eff == '0) || (h_eff == '0) || (l_eff == '0) || (quo == '0);
  assign st.not_loaded = TOTAL_W'(loaded) < total;
  assign load_ok       = !st.too_big && st.not_loaded;

  always_comb begin
    if (st.too_big) begin
      code = STAT_SIZE;
    end else if (st.empty) begin
      code = STAT_EMPTY;
    end else if (st.not_loaded) begin
      code = STAT_PENDING;
    end else begin
      code = STAT_OK;
    end
  end

  assign lane_last = (L_W'(lane_pos) + L_W'(1)) == l_eff;
  assign col_last  = (W_W'(col_pos) + W_W'(1)) == w_eff;
  assign grp_last  = (C_W'(group_pos) + C_W'(1)) == quo;
  assign row_last  = (H_W'(row_pos) + H_W'(1)) == h_eff;
  assign last_now  = lane_last && col_last && grp_last && row_last;

  assign gstart_nx   = gstart + stride;
  assign row_base_nx = row_base + ADDR_W'(w_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_w     <= W_W'(1);
      reg_h     <= H_W'(1);
      reg_c     <= C_W'(1);
      reg_l     <= L_W'(1);
      loaded    <= '0;
      lane_pos  <= '0;
      col_pos   <= '0;
      group_pos <= '0;
      row_pos   <= '0;
      row_base  <= '0;
      gstart    <= '0;
      cbase     <= '0;
      addr      <= '0;
    end else if (cfg_we || (cmd.rd_issue && last_now)) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:    reg_w <= cfg_data[W_W-1:0];
          REG_HEIGHT:   reg_h <= cfg_data[H_W-1:0];
          REG_CHANNELS: reg_c <= cfg_data[C_W-1:0];
          REG_LANES:    reg_l <= cfg_data[L_W-1:0];
          default:      reg_w <= reg_w;
        endcase
      end
      // rearm
      loaded    <= '0;
      lane_pos  <= '0;
      col_pos   <= '0;
      group_pos <= '0;
      row_pos   <= '0;
      row_base  <= '0;
      gstart    <= '0;
      cbase     <= '0;
      addr      <= '0;
    end else if (cmd.load && load_ok) begin
      loaded <= loaded + CNT_W'(1);
    end else if (cmd.rd_issue) begin
      if (!lane_last) begin
        lane_pos <= lane_pos + LANE_W'(1);
        addr     <= addr + wh[ADDR_W-1:0];
      end else begin
        lane_pos <= '0;
        if (!col_last) begin
          col_pos <= col_pos + COL_W'(1);
          cbase   <= cbase + ADDR_W'(1);
          addr    <= cbase + ADDR_W'(1);
        end else begin
          col_pos <= '0;
          if (!grp_last) begin
            group_pos <= group_pos + GRP_W'(1);
            gstart    <= gstart_nx;
            cbase     <= gstart_nx;
            addr      <= gstart_nx;
          end else begin
            group_pos <= '0;
            row_pos   <= row_pos + ROW_W'(1);
            row_base  <= row_base_nx;
            gstart    <= row_base_nx;
            cbase     <= row_base_nx;
            addr      <= row_base_nx;
          end
        end
      end
    end
  end

  // element store, single port
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem[loaded[ADDR_W-1:0]] <= element_value;
    end
    if (cmd.rd_issue) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      pend_last <= last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.rd_err || cmd.rd_resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_err) begin
      out_value <= '0;
      status    <= code;
      last_flag <= 1'b0;
    end else if (cmd.rd_resp) begin
      out_value <= $signed(rdata);
      status    <= STAT_OK;
      last_flag <= pend_last;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/channel_group_tensor_reorder.sv -----
// Top level of the channel-group tensor reorder block.
`timescale 1ns / 1ps
`default_nettype none
// Reorders a (channel, row, column) tensor into row, channel-group, column,
// lane order. A request is taken when start is high and busy is low; mode 0
// loads the next source element (no result), mode 1 reads the next reordered
// element. A read of a fully loaded tensor reads the single-port element
// store, holds busy for one cycle and strobes done after the READ state; a
// read that answers with an error status (not loaded, empty tensor, size
// over capacity) strobes done the cycle after the request. Each result
// appears on out_value/status/last_flag in the cycle that done is high and
// holds until the next result: the receiver cannot stall, so sample it
// then. After reset and after every register write, busy stays high while
// the derived sizes are rebuilt (width*height, the element total, the group
// stride and an 11-step restoring divide for channels/lanes). The store has
// no clearing pass: every read entry was loaded since the last rearm. A
// register write rearms the tensor; the flagged last read rearms it too.
module channel_group_tensor_reorder (
  input  wire                                 clk,
  input  wire                                 rst,
  // request channel
  input  wire                                 start,
  output logic                                busy,
  input  wire                                 mode,
  input  wire  signed [cgtr_pkg::DATA_W-1:0]  element_value,
  // result channel
  output logic                                done,
  output logic signed [cgtr_pkg::DATA_W-1:0]  out_value,
  output logic [1:0]                          status,
  output logic                                last_flag,
  // register write channel
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [cgtr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [cgtr_pkg::CFG_W-1:0]          cfg_data
);
  import cgtr_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t st;
  logic       cfg_we;

  // register writes are always taken; they restart the size math
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  cgtr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .cfg_we (cfg_we),
    .st     (st),
    .cmd    (cmd),
    .busy   (busy)
  );

  cgtr_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .element_value (element_value),
    .st            (st),
    .done          (done),
    .out_value     (out_value),
    .status        (status),
    .last_flag     (last_flag)
  );

endmodule
`default_nettype wire
